[hw/rtl/i2c_master_transaction_sequencer_unit_assert.svh]
// Assertion macros for the I2C master transaction sequencer checker.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define I2CMTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/i2cmts_pkg.sv]
// Shared types and codes of the I2C master transaction sequencer.
package i2cmts_pkg;

    localparam int CMD_W      = 2;
    localparam int ACT_W      = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_REGREAD  = 2'd2;
    localparam logic [1:0] KIND_REGWRITE = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEND    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RX_ACK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RX_NACK = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd5;

    localparam logic [7:0] STATUS_MASK  = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    typedef struct packed {
        logic [7:0] bus_status;
        logic [4:0] buffer_index;
        logic [7:0] data_byte;
        logic [5:0] length;
        logic [1:0] kind;
        logic [6:0] slave_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0] error_code;
        logic       error_flag;
        logic       done_res;
        logic       finished_flag;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] tx_byte;
    } out_item_t;

endpackage

[hw/rtl/i2c_master_transaction_sequencer_unit.sv]
// Top level of the I2C master transaction sequencer.
// Takes one input transaction per clock cycle unless the output stalls, and gives its
// result in the next cycle through a single output register; a new input is taken
// in the same cycle as the pending result leaves. Every input, including loads and
// status events while idle, yields exactly one result. The write buffer sits in a
// synchronous RAM of BUFFER_DEPTH bytes: loads write it and the buffer pointer reads
// it at acceptance, and the read data joins the result in the output stage. The RAM
// is not cleared after reset; entries must be loaded before a write sends them.
module i2c_master_transaction_sequencer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // slave_address[6:0], kind[8:7], length[14:9], data_byte[22:15],
    // buffer_index[27:23], bus_status[35:28], zero[39:36]
    input  logic [i2cmts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [i2cmts_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tx_byte[7:0], rx_valid[8], rx_byte[16:9], busy_res[17], finished_flag[18],
    // done_res[19], error_flag[20], error_code[28:21], zero[31:29]
    output logic [i2cmts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // action[2:0]
    output logic [i2cmts_pkg::ACT_W-1:0]       m_axis_tuser
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

    i2cmts_pkg::in_item_t  in_item;
    i2cmts_pkg::out_item_t out_item;
    logic                  accept;
    logic [7:0]            status;
    logic [5:0]            rem_dec;
    logic                  send_req;
    logic                  load_en;
    logic [PTR_W-1:0]      load_addr;

    logic [7:0]            buf_mem [BUFFER_DEPTH];
    logic [7:0]            rd_data_reg;

    logic                  busy_reg, busy_next;
    logic                  rd_reg, rd_next;
    logic                  err_reg, err_next;
    logic                  regrd_reg, regrd_next;
    logic                  prewr_reg, prewr_next;
    logic                  fin_reg, fin_next;
    logic [7:0]            addr_reg, addr_next;
    logic [7:0]            regb_reg, regb_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [5:0]            rem_reg, rem_next;
    logic [7:0]            last_err_reg, last_err_next;

    logic                  out_valid_reg;
    logic [2:0]            act_reg, act_next;
    logic [7:0]            tx_reg, tx_next;
    logic                  tx_mem_reg, tx_mem_next;
    logic                  rxv_reg, rxv_next;
    logic [7:0]            rxb_reg, rxb_next;
    logic                  done_reg, done_next;

    assign in_item       = i2cmts_pkg::in_item_t'(s_axis_tdata[35:0]);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign status        = in_item.bus_status & i2cmts_pkg::STATUS_MASK;
    assign rem_dec       = (rem_reg != 6'd0) ? rem_reg - 6'd1 : 6'd0;
    assign load_en       = accept && (s_axis_tuser == i2cmts_pkg::CMD_LOAD)
                           && ({3'b000, in_item.buffer_index} < DEPTH_B);
    assign load_addr     = PTR_W'({3'b000, in_item.buffer_index});

    always_comb
    begin
        busy_next     = busy_reg;
        rd_next       = rd_reg;
        err_next      = err_reg;
        regrd_next    = regrd_reg;
        prewr_next    = prewr_reg;
        fin_next      = fin_reg;
        addr_next     = addr_reg;
        regb_next     = regb_reg;
        ptr_next      = ptr_reg;
        rem_next      = rem_reg;
        last_err_next = last_err_reg;
        act_next      = i2cmts_pkg::ACT_NONE;
        tx_next       = 8'd0;
        tx_mem_next   = 1'b0;
        rxv_next      = 1'b0;
        rxb_next      = 8'd0;
        done_next     = 1'b0;
        send_req      = 1'b0;
        case (s_axis_tuser)
            i2cmts_pkg::CMD_START:
            begin
                if (!busy_reg)
                begin
                    busy_next  = 1'b1;
                    rd_next    = (in_item.kind == i2cmts_pkg::KIND_READ);
                    regrd_next = (in_item.kind == i2cmts_pkg::KIND_REGREAD);
                    prewr_next = (in_item.kind == i2cmts_pkg::KIND_REGWRITE);
                    err_next   = 1'b0;
                    fin_next   = 1'b0;
                    if (in_item.kind inside {i2cmts_pkg::KIND_REGREAD,
                                             i2cmts_pkg::KIND_REGWRITE})
                    begin
                        regb_next = in_item.data_byte;
                    end
                    addr_next = {in_item.slave_address,
                                 in_item.kind == i2cmts_pkg::KIND_READ};
                    if ((in_item.kind == i2cmts_pkg::KIND_READ) && (in_item.length == 6'd0))
                    begin
                        rem_next = 6'd1;
                    end
                    else
                    begin
                        rem_next = in_item.length;
                    end
                    ptr_next      = '0;
                    last_err_next = 8'd0;
                    act_next      = i2cmts_pkg::ACT_START;
                end
            end
            i2cmts_pkg::CMD_STATUS:
            begin
                if (busy_reg)
                begin
                    case (status)
                        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART:
                        begin
                            act_next = i2cmts_pkg::ACT_SEND;
                            tx_next  = addr_reg;
                        end
                        i2cmts_pkg::ST_SLA_W_ACK:
                        begin
                            if (regrd_reg)
                            begin
                                act_next = i2cmts_pkg::ACT_SEND;
                                tx_next  = regb_reg;
                            end
                            else if (prewr_reg)
                            begin
                                prewr_next = 1'b0;
                                act_next   = i2cmts_pkg::ACT_SEND;
                                tx_next    = regb_reg;
                            end
                            else
                            begin
                                send_req = 1'b1;
                            end
                        end
                        i2cmts_pkg::ST_DATA_ACK:
                        begin
                            if (regrd_reg)
                            begin
                                rd_next    = 1'b1;
                                regrd_next = 1'b0;
                                addr_next  = addr_reg | 8'd1;
                                act_next   = i2cmts_pkg::ACT_START;
                            end
                            else
                            begin
                                send_req = 1'b1;
                            end
                        end
                        i2cmts_pkg::ST_SLA_R_ACK:
                        begin
                            act_next = (rem_reg > 6'd1) ? i2cmts_pkg::ACT_RX_ACK
                                                        : i2cmts_pkg::ACT_RX_NACK;
                        end
                        i2cmts_pkg::ST_RX_ACK:
                        begin
                            rxv_next = 1'b1;
                            rxb_next = in_item.data_byte;
                            rem_next = rem_dec;
                            act_next = (rem_dec > 6'd1) ? i2cmts_pkg::ACT_RX_ACK
                                                        : i2cmts_pkg::ACT_RX_NACK;
                        end
                        i2cmts_pkg::ST_RX_NACK:
                        begin
                            rxv_next      = 1'b1;
                            rxb_next      = in_item.data_byte;
                            rem_next      = rem_dec;
                            act_next      = i2cmts_pkg::ACT_STOP;
                            fin_next      = 1'b1;
                            last_err_next = 8'd0;
                            done_next     = 1'b1;
                        end
                        default:
                        begin
                            last_err_next = status;
                            act_next      = i2cmts_pkg::ACT_STOP;
                            err_next      = 1'b1;
                            fin_next      = 1'b1;
                            done_next     = 1'b1;
                        end
                    endcase
                    if (send_req)
                    begin
                        if (rem_reg != 6'd0)
                        begin
                            act_next    = i2cmts_pkg::ACT_SEND;
                            tx_mem_next = 1'b1;
                            ptr_next    = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                            rem_next    = rem_reg - 6'd1;
                        end
                        else
                        begin
                            act_next  = i2cmts_pkg::ACT_STOP;
                            done_next = 1'b1;
                        end
                    end
                    if (done_next)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the buffer; every accepted item reads at the pointer, loads included.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            buf_mem[load_addr] <= in_item.data_byte;
        end
        if (accept)
        begin
            rd_data_reg <= buf_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_reg        <= 1'b0;
            err_reg       <= 1'b0;
            regrd_reg     <= 1'b0;
            prewr_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            addr_reg      <= 8'd0;
            regb_reg      <= 8'd0;
            ptr_reg       <= '0;
            rem_reg       <= 6'd0;
            last_err_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg     <= busy_next;
                rd_reg       <= rd_next;
                err_reg      <= err_next;
                regrd_reg    <= regrd_next;
                prewr_reg    <= prewr_next;
                fin_reg      <= fin_next;
                addr_reg     <= addr_next;
                regb_reg     <= regb_next;
                ptr_reg      <= ptr_next;
                rem_reg      <= rem_next;
                last_err_reg <= last_err_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= act_next;
            tx_reg     <= tx_next;
            tx_mem_reg <= tx_mem_next;
            rxv_reg    <= rxv_next;
            rxb_reg    <= rxb_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        out_item.tx_byte       = tx_mem_reg ? rd_data_reg : tx_reg;
        out_item.rx_valid      = rxv_reg;
        out_item.rx_byte       = rxb_reg;
        out_item.busy_res      = busy_reg;
        out_item.finished_flag = fin_reg;
        out_item.done_res      = done_reg;
        out_item.error_flag    = err_reg;
        out_item.error_code    = last_err_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_item};
    assign m_axis_tuser  = act_reg;

endmodule

[hw/rtl/i2cmts_checker.sv]
// Port checker of the I2C master transaction sequencer, with its bind.
`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2cmts_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [i2cmts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [i2cmts_pkg::CMD_W-1:0]       s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [i2cmts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [i2cmts_pkg::ACT_W-1:0]       m_axis_tuser
);

    i2cmts_pkg::out_item_t res;
    logic                  unused_in;

    assign res       = i2cmts_pkg::out_item_t'(m_axis_tdata[28:0]);
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    `I2CMTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result transaction changed while stalled")

    `I2CMTS_ASSERT_SAME(a_done_stop, m_axis_tvalid && res.done_res,
        !res.busy_res && (m_axis_tuser == i2cmts_pkg::ACT_STOP),
        "done without stop or with busy still set")

    `I2CMTS_ASSERT_SAME(a_err_fin, m_axis_tvalid && res.error_flag,
        res.finished_flag && !res.busy_res,
        "error flag without finished mark")

    `I2CMTS_ASSERT_SAME(a_rx_act, m_axis_tvalid && res.rx_valid,
        (m_axis_tuser == i2cmts_pkg::ACT_RX_ACK) || (m_axis_tuser == i2cmts_pkg::ACT_RX_NACK)
        || (m_axis_tuser == i2cmts_pkg::ACT_STOP),
        "received byte with a non-receive action")

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_i2cmts_checker (.*);

[tb/tb_i2c_master_transaction_sequencer_unit.sv]
// Testbench for the I2C master transaction sequencer: directed table, then random bus traffic.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer_unit;
    import i2cmts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int DEPTH = 32;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        out_item_t        o;
    } bus_result_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        in_item_t         it;
        logic             fixed;
        bus_result_t      want;
    } stim_row_t;

    localparam bus_result_t NO_CHECK = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [ACT_W-1:0]      m_axis_tuser;

    // sequencer state as predicted
    logic       sq_busy, sq_read, sq_error, sq_regread, sq_prewrite, sq_finished;
    logic [7:0] sq_addr;
    logic [7:0] sq_reg;
    logic [7:0] sq_buf [DEPTH];
    logic [DEPTH-1:0] sq_loaded;
    logic [4:0] sq_ptr;
    logic [5:0] sq_remaining;
    logic [7:0] sq_last_err;

    bus_result_t expected_results[$];
    int          mismatch_count;
    int          stimulus_count;
    logic [7:0]  bus_next;
    logic        sender_burst;

    i2c_master_transaction_sequencer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic in_item_t item(input logic [6:0] addr, input logic [1:0] kind,
                                      input logic [5:0] len, input logic [7:0] data,
                                      input logic [4:0] idx, input logic [7:0] status);
        in_item_t it;
        it.slave_address = addr;
        it.kind          = kind;
        it.length        = len;
        it.data_byte     = data;
        it.buffer_index  = idx;
        it.bus_status    = status;
        return it;
    endfunction

    function automatic bus_result_t lit(input logic [ACT_W-1:0] act, input logic busy,
                                        input logic fin, input logic done, input logic err,
                                        input logic [7:0] code);
        bus_result_t r;
        r = '0;
        r.action          = act;
        r.o.busy_res      = busy;
        r.o.finished_flag = fin;
        r.o.done_res      = done;
        r.o.error_flag    = err;
        r.o.error_code    = code;
        return r;
    endfunction

    function automatic bus_result_t predict_bus_decision(input logic [CMD_W-1:0] cmd,
                                                         input in_item_t it);
        bus_result_t r;
        logic [7:0]  st;
        logic        done;
        logic        want_byte;
        r         = '0;
        done      = 1'b0;
        want_byte = 1'b0;
        st        = it.bus_status & STATUS_MASK;
        case (cmd)
            CMD_LOAD:
            begin
                sq_buf[it.buffer_index]    = it.data_byte;
                sq_loaded[it.buffer_index] = 1'b1;
            end
            CMD_START:
            begin
                if (!sq_busy)
                begin
                    sq_busy     = 1'b1;
                    sq_read     = (it.kind == KIND_READ);
                    sq_regread  = (it.kind == KIND_REGREAD);
                    sq_prewrite = (it.kind == KIND_REGWRITE);
                    sq_error    = 1'b0;
                    sq_finished = 1'b0;
                    if (it.kind == KIND_REGREAD || it.kind == KIND_REGWRITE)
                        sq_reg = it.data_byte;
                    sq_remaining = (it.kind == KIND_READ && it.length == 0) ? 6'd1 : it.length;
                    sq_addr      = {it.slave_address, it.kind == KIND_READ};
                    sq_ptr       = '0;
                    sq_last_err  = '0;
                    r.action     = ACT_START;
                end
            end
            CMD_STATUS:
            begin
                if (sq_busy)
                begin
                    case (st)
                        ST_START, ST_RESTART:
                        begin
                            r.action    = ACT_SEND;
                            r.o.tx_byte = sq_addr;
                        end
                        ST_SLA_W_ACK:
                        begin
                            if (sq_regread || sq_prewrite)
                            begin
                                sq_prewrite = sq_regread ? sq_prewrite : 1'b0;
                                r.action    = ACT_SEND;
                                r.o.tx_byte = sq_reg;
                            end
                            else
                            begin
                                want_byte = 1'b1;
                            end
                        end
                        ST_DATA_ACK:
                        begin
                            if (sq_regread)
                            begin
                                sq_read    = 1'b1;
                                sq_regread = 1'b0;
                                sq_addr[0] = 1'b1;
                                r.action   = ACT_START;
                            end
                            else
                            begin
                                want_byte = 1'b1;
                            end
                        end
                        ST_SLA_R_ACK:
                            r.action = (sq_remaining > 1) ? ACT_RX_ACK : ACT_RX_NACK;
                        ST_RX_ACK:
                        begin
                            r.o.rx_valid = 1'b1;
                            r.o.rx_byte  = it.data_byte;
                            if (sq_remaining != 0)
                                sq_remaining--;
                            r.action = (sq_remaining > 1) ? ACT_RX_ACK : ACT_RX_NACK;
                        end
                        ST_RX_NACK:
                        begin
                            r.o.rx_valid = 1'b1;
                            r.o.rx_byte  = it.data_byte;
                            if (sq_remaining != 0)
                                sq_remaining--;
                            r.action    = ACT_STOP;
                            sq_finished = 1'b1;
                            sq_last_err = '0;
                            done        = 1'b1;
                        end
                        default:
                        begin
                            sq_last_err = st;
                            r.action    = ACT_STOP;
                            sq_error    = 1'b1;
                            sq_finished = 1'b1;
                            done        = 1'b1;
                        end
                    endcase
                    if (want_byte)
                    begin
                        if (sq_remaining != 0)
                        begin
                            r.action    = ACT_SEND;
                            r.o.tx_byte = sq_buf[sq_ptr];
                            sq_ptr++;
                            sq_remaining--;
                        end
                        else
                        begin
                            r.action = ACT_STOP;
                            done     = 1'b1;
                        end
                    end
                    if (done)
                        sq_busy = 1'b0;
                end
            end
            default: ;
        endcase
        r.o.busy_res      = sq_busy;
        r.o.finished_flag = sq_finished;
        r.o.done_res      = done;
        r.o.error_flag    = sq_error;
        r.o.error_code    = sq_last_err;
        return r;
    endfunction

    // a status that would send a buffer entry never loaded
    function automatic logic reads_unloaded(input logic [7:0] status);
        logic [7:0] st;
        st = status & STATUS_MASK;
        return sq_busy && sq_remaining != 0 && !sq_loaded[sq_ptr]
            && ((st == ST_SLA_W_ACK && !sq_regread && !sq_prewrite)
                || (st == ST_DATA_ACK && !sq_regread));
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [CMD_W-1:0] cmd, input in_item_t it, input logic fixed,
                         input bus_result_t want);
        bus_result_t pred;
        logic        ignored;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - $bits(in_item_t)){1'b0}}, it};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ignored = (cmd == CMD_NOP) || (cmd == CMD_STATUS && !sq_busy)
                  || (cmd == CMD_START && sq_busy);
        pred = predict_bus_decision(cmd, it);
        expected_results.push_back(fixed ? want : pred);
        if (!ignored)
            stimulus_count++;
        case (pred.action)
            ACT_START:   bus_next = $urandom_range(0, 1) ? ST_START : ST_RESTART;
            ACT_SEND:
            begin
                if ((it.bus_status & STATUS_MASK) == ST_START
                    || (it.bus_status & STATUS_MASK) == ST_RESTART)
                    bus_next = pred.o.tx_byte[0] ? ST_SLA_R_ACK : ST_SLA_W_ACK;
                else
                    bus_next = ST_DATA_ACK;
            end
            ACT_RX_ACK:  bus_next = ST_RX_ACK;
            ACT_RX_NACK: bus_next = ($urandom_range(0, 9) == 0) ? ST_RX_ACK : ST_RX_NACK;
            default: ;
        endcase
        if ($urandom_range(0, 99) < 3)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin
        bus_result_t want;
        out_item_t   got;
        int          stall_left;
        logic        recv_burst;
        stall_left    = 0;
        recv_burst    = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: action %0d data 0x%0h", m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", 8'(want.action), 8'(m_axis_tuser));
                    check_field("tx_byte", want.o.tx_byte, got.tx_byte);
                    check_field("rx_valid", 8'(want.o.rx_valid), 8'(got.rx_valid));
                    check_field("rx_byte", want.o.rx_byte, got.rx_byte);
                    check_field("busy_res", 8'(want.o.busy_res), 8'(got.busy_res));
                    check_field("finished_flag", 8'(want.o.finished_flag),
                                8'(got.finished_flag));
                    check_field("done_res", 8'(want.o.done_res), 8'(got.done_res));
                    check_field("error_flag", 8'(want.o.error_flag), 8'(got.error_flag));
                    check_field("error_code", want.o.error_code, got.error_code);
                end
            end
            if ($urandom_range(0, 99) == 0)
                recv_burst = !recv_burst;
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall_left = recv_burst ? 0 : idle_len();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        stim_row_t        rows[$];
        in_item_t         it;
        logic [CMD_W-1:0] cmd;
        int               target;
        int               prefix;
        int               limit;
        int               r;
        int               n;

        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= CMD_NOP;
        mismatch_count = 0;
        stimulus_count = 0;
        bus_next       = ST_START;
        sender_burst   = 1'b0;
        sq_busy        = 1'b0;
        sq_read        = 1'b0;
        sq_error       = 1'b0;
        sq_regread     = 1'b0;
        sq_prewrite    = 1'b0;
        sq_finished    = 1'b0;
        sq_addr        = '0;
        sq_reg         = '0;
        sq_loaded      = '0;
        sq_ptr         = '0;
        sq_remaining   = '0;
        sq_last_err    = '0;

        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_START), 1'b1,
                        lit(ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00)});
        rows.push_back({CMD_NOP, item(7'h7F, KIND_REGWRITE, 6'd32, 8'hFF, 5'd31, 8'hFF), 1'b1,
                        lit(ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00)});
        rows.push_back({CMD_LOAD, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, 8'h00), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_LOAD, item(7'h00, KIND_WRITE, 6'd0, 8'hFF, 5'd1, 8'h00), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_LOAD, item(7'h00, KIND_WRITE, 6'd0, 8'h5A, 5'd2, 8'h00), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_LOAD, item(7'h00, KIND_WRITE, 6'd0, 8'hA5, 5'd31, 8'h00), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_START, item(7'h7F, KIND_WRITE, 6'd2, 8'h33, 5'd0, 8'h00), 1'b1,
                        lit(ACT_START, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00)});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, 8'h0F), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_SLA_W_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, 8'h2F), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_DATA_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_START, item(7'h00, KIND_READ, 6'd0, 8'h00, 5'd0, 8'h00), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_START),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_SLA_R_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h12, 5'd0, ST_RX_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'hEE, 5'd0, 8'h57), 1'b0,
                        NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'hFF, 5'd0, ST_RX_NACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_START, item(7'h55, KIND_REGREAD, 6'd32, 8'h80, 5'd0, 8'h00),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_START, item(7'h01, KIND_WRITE, 6'd1, 8'h00, 5'd0, 8'h00), 1'b1,
                        lit(ACT_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00)});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_START),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_SLA_W_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_DATA_ACK),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, ST_RESTART),
                        1'b0, NO_CHECK});
        rows.push_back({CMD_STATUS, item(7'h00, KIND_WRITE, 6'd0, 8'h00, 5'd0, 8'h60), 1'b1,
                        lit(ACT_STOP, 1'b0, 1'b1, 1'b1, 1'b1, 8'h60)});
        rows.push_back({CMD_START, item(7'h2A, KIND_REGWRITE, 6'd1, 8'h3C, 5'd0, 8'h00),
                        1'b0, NO_CHECK});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue(rows[i].cmd, rows[i].it, rows[i].fixed, rows[i].want);

        target = stimulus_count + RANDOM_ITEMS;
        while (stimulus_count < target)
        begin
            prefix = 0;
            while (prefix < DEPTH && sq_loaded[prefix])
                prefix++;
            it.slave_address = 7'($urandom);
            it.kind          = 2'($urandom);
            it.length        = 6'($urandom_range(0, 32));
            it.data_byte     = 8'($urandom);
            it.buffer_index  = 5'($urandom);
            it.bus_status    = 8'($urandom);
            r = $urandom_range(0, 99);
            if (sq_busy && r < 82)
            begin
                cmd = CMD_STATUS;
                it.bus_status = bus_next | 8'($urandom_range(0, 7));
            end
            else if (!sq_busy && r < 55)
            begin
                cmd   = CMD_START;
                limit = (it.kind == KIND_WRITE || it.kind == KIND_REGWRITE) ? prefix : 32;
                if ($urandom_range(0, 99) < 80)
                    it.length = 6'($urandom_range(0, limit < 4 ? limit : 4));
                else
                    it.length = 6'($urandom_range(0, limit));
            end
            else if (!sq_busy && r < 78)
            begin
                cmd = CMD_LOAD;
                if (prefix < DEPTH && $urandom_range(0, 99) < 70)
                    it.buffer_index = 5'(prefix);
            end
            else
            begin
                n = $urandom_range(0, 9);
                if (n < 4)
                    cmd = CMD_STATUS;
                else if (n < 6)
                    cmd = CMD_LOAD;
                else if (n < 8)
                    cmd = CMD_START;
                else
                    cmd = CMD_NOP;
            end
            if (cmd == CMD_STATUS)
                while (reads_unloaded(it.bus_status))
                    it.bus_status = 8'($urandom);
            issue(cmd, it, 1'b0, NO_CHECK);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
